@@ rtl/rcws_pkg.sv @@
// rcws_pkg: shared constants, request struct and frame/CRC helpers for the
// relay coil write scheduler. No dependencies.
`default_nettype none

package rcws_pkg;

  // Default sizes
  localparam int NUM_BOARDS_DEF  = 16;
  localparam int GPIO_BOARDS_DEF = 4;
  localparam int BOARD_W         = 4;
  localparam int MASK_W          = 8;
  localparam int FRAME_LEN       = 10;

  // Request codes
  localparam logic REQ_INVERT = 1'b0;
  localparam logic REQ_POLL   = 1'b1;

  // Status codes
  localparam logic [1:0] ST_NONE      = 2'd0;
  localparam logic [1:0] ST_ACCEPTED  = 2'd1;
  localparam logic [1:0] ST_RANGE_ERR = 2'd2;
  localparam logic [1:0] ST_DATA_ERR  = 2'd3;

  // Frame constants
  localparam logic [7:0]  FUNC_WRITE_COILS = 8'h0F;
  localparam logic [7:0]  ZERO_BYTE        = 8'h00;
  localparam logic [7:0]  COIL_QTY         = 8'h08;
  localparam logic [7:0]  BYTE_COUNT       = 8'h01;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;

  // Byte positions in the frame
  localparam logic [3:0] POS_ID     = 4'd0;
  localparam logic [3:0] POS_FUNC   = 4'd1;
  localparam logic [3:0] POS_ADR_HI = 4'd2;
  localparam logic [3:0] POS_ADR_LO = 4'd3;
  localparam logic [3:0] POS_QTY_HI = 4'd4;
  localparam logic [3:0] POS_QTY_LO = 4'd5;
  localparam logic [3:0] POS_COUNT  = 4'd6;
  localparam logic [3:0] POS_MASK   = 4'd7;
  localparam logic [3:0] POS_CRC_HI = 4'd8;
  localparam logic [3:0] POS_CRC_LO = 4'd9;

  // Scan result handed to the frame emitter
  typedef struct packed {
    logic               nomatch;
    logic [BOARD_W-1:0] board;
    logic [MASK_W-1:0]  mask;
    logic [1:0]         status;
  } frame_req_t;

  // One byte of CRC-16/MODBUS, bit-serial over eight narrow steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Header and payload bytes of the write-coils frame
  function automatic logic [7:0] frame_byte(input logic [3:0]         pos,
                                            input logic [BOARD_W-1:0] board,
                                            input logic [MASK_W-1:0]  mask);
    logic [7:0] v;
    unique case (pos)
      POS_ID:     v = 8'({4'h0, board}) + 8'd1;
      POS_FUNC:   v = FUNC_WRITE_COILS;
      POS_ADR_HI: v = ZERO_BYTE;
      POS_ADR_LO: v = ZERO_BYTE;
      POS_QTY_HI: v = ZERO_BYTE;
      POS_QTY_LO: v = COIL_QTY;
      POS_COUNT:  v = BYTE_COUNT;
      POS_MASK:   v = mask;
      default:    v = ZERO_BYTE;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/relay_coil_write_scheduler.sv @@
// relay_coil_write_scheduler: top level; reply handling, board scan over the
// state memories, frame emitter. Depends on rcws_pkg, rcws_ram, rcws_frame.
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------------
//   in      | in_valid / in_ready | req_type board_sel invert_mask rx_present
//           |                     | rx_unit_id rx_quantity gpio_inputs
//   out     | out_valid/out_ready | tx_byte byte_valid last status
//
// An invert write is stored on accept. A poll is accepted and then scans up
// to NUM_BOARDS boards, one board read per cycle from the two state RAMs with
// the compare on the registered read data, until one mismatches; it then
// emits ten beats (or one status beat if none does) before input reopens.
// Reset clears per-entry valid bits at once; no clearing pass is needed.
// A stalled output holds in the output register; input is taken again once
// the last beat of a poll is loaded there and the sequencer is back in idle.
`default_nettype none

module relay_coil_write_scheduler #(
  parameter int NUM_BOARDS  = rcws_pkg::NUM_BOARDS_DEF,
  parameter int GPIO_BOARDS = rcws_pkg::GPIO_BOARDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [3:0]  board_sel,
  input  wire logic [7:0]  invert_mask,
  input  wire logic        rx_present,
  input  wire logic [7:0]  rx_unit_id,
  input  wire logic [7:0]  rx_quantity,
  input  wire logic [31:0] gpio_inputs,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       tx_byte,
  output logic             byte_valid,
  output logic             last,
  output logic [1:0]       status
);
  import rcws_pkg::*;

  localparam int AW = (NUM_BOARDS > 1) ? $clog2(NUM_BOARDS) : 1;
  localparam logic [BOARD_W-1:0] LAST_B = BOARD_W'(NUM_BOARDS - 1);
  localparam logic [4:0]         NB5    = 5'(NUM_BOARDS);
  localparam logic [7:0]         NB8    = 8'(NUM_BOARDS);
  localparam logic [4:0]         GB5    = 5'(GPIO_BOARDS);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WAIT} state_t;

  state_t              state;
  logic [MASK_W-1:0]   last_sent_mask;
  logic [BOARD_W-1:0]  scan_start;
  logic [BOARD_W-1:0]  scan_b;
  logic [4:0]          iss_cnt;
  logic                pend;
  logic [BOARD_W-1:0]  pend_b;
  logic                pend_cv;
  logic                pend_iv;
  logic [1:0]          status_q;
  logic [31:0]         gpio_q;
  logic [NUM_BOARDS-1:0] cur_vld;
  logic [NUM_BOARDS-1:0] inv_vld;

  logic                accept;
  logic [7:0]          reply_board;
  logic [1:0]          status_new;
  logic                cur_we;
  logic                inv_we;
  logic [MASK_W-1:0]   cur_q;
  logic [MASK_W-1:0]   inv_q;
  logic [MASK_W-1:0]   cur_d;
  logic [MASK_W-1:0]   gpio_byte;
  logic [MASK_W-1:0]   desired;
  logic                mismatch;
  logic                issue;
  logic                done_none;
  logic                fr_start;
  logic                fr_busy;
  frame_req_t          fr_req;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Reply decode
  assign reply_board = rx_unit_id - 8'd1;
  always_comb begin
    if (!rx_present) begin
      status_new = ST_NONE;
    end else if (rx_quantity != COIL_QTY) begin
      status_new = ST_DATA_ERR;
    end else if (reply_board < NB8) begin
      status_new = ST_ACCEPTED;
    end else begin
      status_new = ST_RANGE_ERR;
    end
  end

  assign cur_we = accept && (req_type == REQ_POLL) && (status_new == ST_ACCEPTED);
  assign inv_we = accept && (req_type == REQ_INVERT) && ({1'b0, board_sel} < NB5);

  // State memories
  rcws_ram #(.WIDTH(MASK_W), .DEPTH(NUM_BOARDS), .AW(AW)) u_cur_ram (
    .clk   (clk),
    .we    (cur_we),
    .waddr (reply_board[AW-1:0]),
    .wdata (last_sent_mask),
    .raddr (scan_b[AW-1:0]),
    .rdata (cur_q)
  );

  rcws_ram #(.WIDTH(MASK_W), .DEPTH(NUM_BOARDS), .AW(AW)) u_inv_ram (
    .clk   (clk),
    .we    (inv_we),
    .waddr (board_sel[AW-1:0]),
    .wdata (invert_mask),
    .raddr (scan_b[AW-1:0]),
    .rdata (inv_q)
  );

  // Compare stage: entries never written read as zero
  assign cur_d     = pend_cv ? cur_q : '0;
  assign gpio_byte = 8'(gpio_q >> {pend_b[1:0], 3'b000});
  assign desired   = (pend_iv ? inv_q : '0)
                   ^ (({1'b0, pend_b} < GB5) ? gpio_byte : '0);
  assign mismatch  = (state == S_SCAN) && pend && (cur_d != desired);
  assign issue     = (state == S_SCAN) && !mismatch && (iss_cnt < NB5);
  assign done_none = (state == S_SCAN) && pend && !mismatch && (iss_cnt == NB5);
  assign fr_start  = mismatch || done_none;

  assign fr_req = '{nomatch: !mismatch, board: pend_b, mask: desired,
                    status: status_q};

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      last_sent_mask <= '0;
      scan_start     <= '0;
      cur_vld        <= '0;
      inv_vld        <= '0;
      pend           <= 1'b0;
      iss_cnt        <= '0;
      scan_b         <= '0;
    end else begin
      if (cur_we) begin
        cur_vld[reply_board[AW-1:0]] <= 1'b1;
      end
      if (inv_we) begin
        inv_vld[board_sel[AW-1:0]] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (req_type == REQ_POLL)) begin
            state    <= S_SCAN;
            status_q <= status_new;
            gpio_q   <= gpio_inputs;
            scan_b   <= scan_start;
            iss_cnt  <= '0;
            pend     <= 1'b0;
          end
        end
        S_SCAN: begin
          pend <= issue;
          if (issue) begin
            pend_b  <= scan_b;
            pend_cv <= cur_vld[scan_b[AW-1:0]];
            pend_iv <= inv_vld[scan_b[AW-1:0]];
            scan_b  <= (scan_b == LAST_B) ? '0 : scan_b + 4'd1;
            iss_cnt <= iss_cnt + 5'd1;
          end
          if (mismatch) begin
            last_sent_mask <= desired;
            scan_start     <= (pend_b == LAST_B) ? '0 : pend_b + 4'd1;
          end
          if (fr_start) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (!fr_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Frame emitter
  rcws_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .start      (fr_start),
    .req        (fr_req),
    .busy       (fr_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .tx_byte    (tx_byte),
    .byte_valid (byte_valid),
    .last       (last),
    .status     (status)
  );

endmodule

`default_nettype wire

@@ rtl/rcws_ram.sv @@
// rcws_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rcws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/rcws_frame.sv @@
// rcws_frame: emits the ten-byte write-coils frame (running CRC) or a single
// status-only beat through an output register. Depends on rcws_pkg.
`default_nettype none

module rcws_frame (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire rcws_pkg::frame_req_t req,
  output logic                     busy,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               tx_byte,
  output logic                     byte_valid,
  output logic                     last,
  output logic [1:0]               status
);
  import rcws_pkg::*;

  frame_req_t  req_q;
  logic [3:0]  pos;
  logic [15:0] crc;
  logic        out_free;
  logic        load;
  logic [7:0]  cur_byte;

  assign out_free = !out_valid || out_ready;
  assign load     = !start && busy && out_free;

  // Byte for the current position
  always_comb begin
    if (pos == POS_CRC_HI) begin
      cur_byte = crc[15:8];
    end else if (pos == POS_CRC_LO) begin
      cur_byte = crc[7:0];
    end else begin
      cur_byte = frame_byte(pos, req_q.board, req_q.mask);
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      pos       <= '0;
      crc       <= CRC_INIT;
    end else begin
      // Output beat held until taken, reloaded when free
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (start) begin
        busy  <= 1'b1;
        req_q <= req;
        pos   <= '0;
        crc   <= CRC_INIT;
      end else if (load) begin
        status <= req_q.status;
        if (req_q.nomatch) begin
          tx_byte    <= ZERO_BYTE;
          byte_valid <= 1'b0;
          last       <= 1'b1;
          busy       <= 1'b0;
        end else begin
          tx_byte    <= cur_byte;
          byte_valid <= 1'b1;
          last       <= (pos == POS_CRC_LO);
          pos        <= pos + 4'd1;
          if (pos <= POS_MASK) begin
            crc <= crc16_byte(crc, cur_byte);
          end
          if (pos == POS_CRC_LO) begin
            busy <= 1'b0;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire
